// ----- hdl/crc16_packet_deframer_macros.svh -----
// ----------------------------------------------------------------------------
// crc16_packet_deframer_macros.svh
// Assertion macros used by the deframer top-level RTL.
// ----------------------------------------------------------------------------
`ifndef CRC16_PACKET_DEFRAMER_MACROS_SVH
`define CRC16_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CRCPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CRCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/crcpd_pkg.sv -----
// ----------------------------------------------------------------------------
// crcpd_pkg
// Shared constants, types and the CRC-CCITT byte step for the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crcpd_pkg;

    localparam logic [7:0]  SOP_BYTE = 8'hA1;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Frame completion event from the receive engine
    typedef struct packed {
        logic       done;
        logic [7:0] ptype;
        logic [7:0] plen;
    } rx_event_t;

    // Reflected CRC-CCITT (poly 0x8408), one byte per call
    function automatic logic [15:0] crc16_step(input logic [7:0] din, input logic [15:0] crc);
        logic [7:0] b;
        b = din ^ crc[7:0];
        b = b ^ {b[3:0], 4'b0000};
        return {b, crc[15:8]} ^ {12'h000, b[7:4]} ^ {5'b00000, b, 3'b000};
    endfunction

endpackage

// ----- hdl/crcpd_ram.sv -----
// ----------------------------------------------------------------------------
// crcpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 200,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/crcpd_rx.sv -----
// ----------------------------------------------------------------------------
// crcpd_rx
// Frame receive engine: header parse, incremental CRC, payload write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcpd_rx
    import crcpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 200,
    parameter int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              feed_en,
    input  logic [7:0]        data_byte,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output rx_event_t         rx_event
);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_CRCLO = 3'd3;
    localparam logic [2:0] PH_CRCHI = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  ftype_reg, ftype_next;
    logic [7:0]  flen_reg, flen_next;
    logic [15:0] exp_crc_reg, exp_crc_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_upd;
    logic [15:0] exp_full;

    assign crc_upd  = crc16_step(data_byte, crc_reg);
    assign exp_full = {data_byte, exp_crc_reg[7:0]};

    assign wr_addr = count_reg[ADDR_W-1:0];
    assign wr_data = data_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        ftype_next     = ftype_reg;
        flen_next      = flen_reg;
        exp_crc_next   = exp_crc_reg;
        crc_next       = crc_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        rx_event.done  = 1'b0;
        rx_event.ptype = ftype_reg;
        rx_event.plen  = flen_reg;
        if (feed_en)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    ftype_next = data_byte;
                    crc_next   = crc16_step(data_byte, CRC_INIT);
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if ({1'b0, data_byte} > 9'(MAX_PAYLOAD))
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        flen_next  = data_byte;
                        crc_next   = crc_upd;
                        phase_next = PH_CRCLO;
                    end
                end
                PH_CRCLO:
                begin
                    exp_crc_next = {8'h00, data_byte};
                    phase_next   = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    exp_crc_next = exp_full;
                    if (flen_reg == 8'd0)
                    begin
                        phase_next    = PH_HUNT;
                        rx_event.done = (crc_reg == exp_full);
                    end
                    else
                    begin
                        count_next = 8'd0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    wr_en      = ({1'b0, count_reg} < 9'(MAX_PAYLOAD));
                    crc_next   = crc_upd;
                    count_next = count_reg + 8'd1;
                    if (({1'b0, count_reg} + 9'd1) >= {1'b0, flen_reg})
                    begin
                        phase_next    = PH_HUNT;
                        rx_event.done = (crc_upd == exp_crc_reg);
                    end
                end
                default:
                begin
                    // hunting, and unused codes recover here
                    phase_next = (data_byte == SOP_BYTE) ? PH_TYPE : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            ftype_reg   <= 8'd0;
            flen_reg    <= 8'd0;
            exp_crc_reg <= 16'd0;
            crc_reg     <= CRC_INIT;
            count_reg   <= 8'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            ftype_reg   <= ftype_next;
            flen_reg    <= flen_next;
            exp_crc_reg <= exp_crc_next;
            crc_reg     <= crc_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ----- hdl/crc16_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// crc16_packet_deframer: framed byte-stream receiver with payload buffer.
// One item per cycle while in_ready is high; a result is registered in stage 1, then in the output register.
// Reads return payload RAM data through one registered-read RAM port.
// Async reset: hunting for SOP, CRC at 0xFFFF, no result held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crc16_packet_deframer_macros.svh"

module crc16_packet_deframer
    import crcpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 200
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] data_byte,
    input  logic [7:0] read_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic [7:0] packet_type,
    output logic [7:0] payload_length,
    output logic [7:0] read_data
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic              in_xfer;
    logic              feed_en;
    logic              rd_cmd;
    logic              rd_in_range;
    logic              out_free;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        ram_rd_data;
    rx_event_t         rx_event;

    logic [7:0] acc_ptype_reg, acc_ptype_next;
    logic [7:0] acc_len_reg, acc_len_next;

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_kind_reg, s1_kind_next;
    logic [7:0] s1_type_reg, s1_type_next;
    logic [7:0] s1_len_reg, s1_len_next;
    logic       s1_zero_reg, s1_zero_next;

    logic       out_valid_reg, out_valid_next;
    logic       out_kind_reg, out_kind_next;
    logic [7:0] out_type_reg, out_type_next;
    logic [7:0] out_len_reg, out_len_next;
    logic [7:0] out_data_reg, out_data_next;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_xfer  = in_valid && in_ready;
    assign feed_en  = in_xfer && (command == CMD_FEED);
    assign rd_cmd   = in_xfer && (command == CMD_READ);
    assign rd_in_range = (read_index < acc_len_reg) &&
                         ({1'b0, read_index} < 9'(MAX_PAYLOAD));

    crcpd_rx #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .feed_en   (feed_en),
        .data_byte (data_byte),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rx_event  (rx_event)
    );

    crcpd_ram #(
        .WIDTH  (8),
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_cmd && rd_in_range),
        .rd_addr (read_index[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Last accepted packet info
    always_comb
    begin
        acc_ptype_next = acc_ptype_reg;
        acc_len_next   = acc_len_reg;
        if (rx_event.done)
        begin
            acc_ptype_next = rx_event.ptype;
            acc_len_next   = rx_event.plen;
        end
    end

    // Stage 1 waits for the RAM read; RAM data is held until it moves on
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_kind_next  = s1_kind_reg;
        s1_type_next  = s1_type_reg;
        s1_len_next   = s1_len_reg;
        s1_zero_next  = s1_zero_reg;
        if (s1_valid_reg && out_free)
        begin
            s1_valid_next = 1'b0;
        end
        if (rd_cmd)
        begin
            s1_valid_next = 1'b1;
            s1_kind_next  = KIND_READ;
            s1_type_next  = acc_ptype_reg;
            s1_len_next   = acc_len_reg;
            s1_zero_next  = !rd_in_range;
        end
        else if (rx_event.done)
        begin
            s1_valid_next = 1'b1;
            s1_kind_next  = KIND_PACKET;
            s1_type_next  = rx_event.ptype;
            s1_len_next   = rx_event.plen;
            s1_zero_next  = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_type_next  = out_type_reg;
        out_len_next   = out_len_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_valid_reg && out_free)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = s1_kind_reg;
            out_type_next  = s1_type_reg;
            out_len_next   = s1_len_reg;
            out_data_next  = s1_zero_reg ? 8'd0 : ram_rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_ptype_reg <= 8'd0;
            acc_len_reg   <= 8'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_ptype_reg <= acc_ptype_next;
            acc_len_reg   <= acc_len_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg  <= s1_kind_next;
        s1_type_reg  <= s1_type_next;
        s1_len_reg   <= s1_len_next;
        s1_zero_reg  <= s1_zero_next;
        out_kind_reg <= out_kind_next;
        out_type_reg <= out_type_next;
        out_len_reg  <= out_len_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_kind_reg;
    assign packet_type    = out_type_reg;
    assign payload_length = out_len_reg;
    assign read_data      = out_data_reg;

    `CRCPD_ASSERT_NEXT(a_s1_holds_on_stall, clk, rst_n,
        s1_valid_reg && !out_free, s1_valid_reg, "stalled read stage lost its result")
    `CRCPD_ASSERT_NEXT(a_pkt_updates_len, clk, rst_n,
        rx_event.done, acc_len_reg == $past(rx_event.plen), "accepted length not updated")
    `CRCPD_ASSERT_NOW(a_acc_len_bound, clk, rst_n,
        1'b1, {1'b0, acc_len_reg} <= 9'(MAX_PAYLOAD), "accepted length above maximum")
    `CRCPD_ASSERT_NOW(a_pkt_no_data, clk, rst_n,
        out_valid_reg && (out_kind_reg == KIND_PACKET), out_data_reg == 8'd0,
        "packet result carries read data")

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: regression for crc16_packet_deframer
// Sends framed byte streams (good, bad CRC, oversize length, truncated) and
// payload reads through the input channel with random gaps. A cycle-free
// receiver model predicts every packet and read result, and each result
// transfer is checked in order. Output stalls include one long hold-off to
// fill the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import crcpd_pkg::*;

    localparam int MAX_LEN     = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 20000;

    typedef enum logic [2:0] {
        PH_HUNT, PH_TYPE, PH_LEN, PH_CRC_LO, PH_CRC_HI, PH_DATA
    } rx_phase_t;

    typedef enum int {
        FLAW_NONE, FLAW_CRC, FLAW_LONG_LEN, FLAW_TRUNCATED
    } frame_flaw_t;

    typedef struct {
        logic       kind;
        logic [7:0] ptype;
        logic [7:0] plen;
        logic [7:0] rdata;
    } deframer_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       command = CMD_FEED;
    logic [7:0] data_byte = 8'h00;
    logic [7:0] read_index = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       result_kind;
    logic [7:0] packet_type;
    logic [7:0] payload_length;
    logic [7:0] read_data;

    // receiver model state
    rx_phase_t  rx_phase_m = PH_HUNT;
    logic [7:0] cur_type = 8'h00;
    logic [7:0] cur_len = 8'h00;
    logic [15:0] hdr_crc = 16'h0000;
    logic [15:0] crc_acc = CRC_INIT;
    logic [7:0] data_count = 8'h00;
    logic [7:0] payload_mem [MAX_LEN];
    logic [7:0] last_type = 8'h00;
    logic [7:0] last_len = 8'h00;

    deframer_result_t pending_results[$];

    int  errors = 0;
    int  items_sent = 0;
    int  packets_seen = 0;
    int  reads_seen = 0;
    bit  gaps_on = 1'b0;
    bit  ready_stalls = 1'b0;
    int  read_mix = 0;
    int  hold_requests = 0;
    int  holds_served = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    crc16_packet_deframer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .data_byte      (data_byte),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .packet_type    (packet_type),
        .payload_length (payload_length),
        .read_data      (read_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("crc16_packet_deframer regression: fail");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Bitwise reflected CRC-CCITT, poly 0x8408
    function automatic logic [15:0] crc_ccitt_byte(logic [15:0] crc, logic [7:0] b);
        crc = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            crc = crc[0] ? ((crc >> 1) ^ 16'h8408) : (crc >> 1);
        return crc;
    endfunction

    function automatic void finish_frame();
        rx_phase_m = PH_HUNT;
        if (crc_acc == hdr_crc)
        begin
            last_type = cur_type;
            last_len  = cur_len;
            pending_results.push_back('{KIND_PACKET, cur_type, cur_len, 8'h00});
        end
    endfunction

    // Advance the receiver model by one accepted transfer
    function automatic void model_item(logic cmd, logic [7:0] d, logic [7:0] idx);
        logic [7:0] v;
        if (cmd == CMD_READ)
        begin
            v = (idx < last_len && idx < MAX_LEN) ? payload_mem[idx] : 8'h00;
            pending_results.push_back('{KIND_READ, last_type, last_len, v});
            return;
        end
        case (rx_phase_m)
            PH_TYPE:
            begin
                cur_type   = d;
                crc_acc    = crc_ccitt_byte(CRC_INIT, d);
                rx_phase_m = PH_LEN;
            end
            PH_LEN:
            begin
                if (d > MAX_LEN)
                    rx_phase_m = PH_HUNT;
                else
                begin
                    cur_len    = d;
                    crc_acc    = crc_ccitt_byte(crc_acc, d);
                    rx_phase_m = PH_CRC_LO;
                end
            end
            PH_CRC_LO:
            begin
                hdr_crc    = {8'h00, d};
                rx_phase_m = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                hdr_crc[15:8] = d;
                if (cur_len == 8'h00)
                    finish_frame();
                else
                begin
                    data_count = 8'h00;
                    rx_phase_m = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (data_count < MAX_LEN)
                    payload_mem[data_count] = d;
                crc_acc    = crc_ccitt_byte(crc_acc, d);
                data_count = data_count + 8'd1;
                if (data_count >= cur_len)
                    finish_frame();
            end
            default:
                rx_phase_m = (d == SOP_BYTE) ? PH_TYPE : PH_HUNT;
        endcase
    endfunction

    function automatic logic [7:0] pick_read_index();
        if (last_len > 0 && $urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, last_len - 1));
        return 8'($urandom_range(0, MAX_LEN - 1));
    endfunction

    // Offer one item; returns right after the edge where it transfers
    task automatic send_item(input logic cmd, input logic [7:0] dbyte, input logic [7:0] idx);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        data_byte  <= dbyte;
        read_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model_item(cmd, dbyte, idx);
        items_sent++;
    endtask

    task automatic send_read(input logic [7:0] idx);
        send_item(CMD_READ, 8'($urandom), idx);
    endtask

    // Stream byte, sometimes preceded by a payload read
    task automatic feed(input logic [7:0] b);
        if ($urandom_range(0, 99) < read_mix)
            send_read(pick_read_index());
        send_item(CMD_FEED, b, 8'($urandom));
    endtask

    task automatic send_frame(input logic [7:0] ptype, input logic [7:0] plen,
                              input frame_flaw_t flaw);
        logic [7:0]  body[$];
        logic [15:0] crc;
        logic [7:0]  b;
        int          cut;
        crc = crc_ccitt_byte(CRC_INIT, ptype);
        crc = crc_ccitt_byte(crc, plen);
        if (plen <= MAX_LEN)
        begin
            for (int i = 0; i < plen; i++)
            begin
                b = 8'($urandom);
                body.push_back(b);
                crc = crc_ccitt_byte(crc, b);
            end
        end
        if (flaw == FLAW_CRC)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        feed(SOP_BYTE);
        feed(ptype);
        feed(plen);
        if (plen > MAX_LEN)
            return;
        feed(crc[7:0]);
        feed(crc[15:8]);
        cut = (flaw == FLAW_TRUNCATED && plen > 0) ? $urandom_range(0, plen - 1) : plen;
        for (int i = 0; i < cut; i++)
            feed(body[i]);
    endtask

    task automatic send_noise(input int count);
        logic [7:0] b;
        for (int i = 0; i < count; i++)
        begin
            b = 8'($urandom);
            if (b == SOP_BYTE)
                b = b ^ 8'h01;
            feed(b);
        end
    endtask

    // Output side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES - 1;
            out_ready    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (ready_stalls && $urandom_range(0, 3) == 0)
        begin
            stall_left <= pick_gap();
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        deframer_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: kind %0d type %0h len %0d data %0h",
                       result_kind, packet_type, payload_length, read_data);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result_kind !== exp_r.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", exp_r.kind, result_kind);
                    errors++;
                end
                if (packet_type !== exp_r.ptype)
                begin
                    $error("packet_type: expected %0h, got %0h", exp_r.ptype, packet_type);
                    errors++;
                end
                if (payload_length !== exp_r.plen)
                begin
                    $error("payload_length: expected %0d, got %0d", exp_r.plen,
                           payload_length);
                    errors++;
                end
                if (read_data !== exp_r.rdata)
                begin
                    $error("read_data: expected %0h, got %0h", exp_r.rdata, read_data);
                    errors++;
                end
                if (exp_r.kind == KIND_PACKET)
                    packets_seen++;
                else
                    reads_seen++;
            end
        end
    end

    task automatic test_directed();
        gaps_on      = 1'b1;
        ready_stalls = 1'b0;
        read_mix     = 0;
        send_item(CMD_FEED, 8'h00, 8'hFF);      // ignored while hunting
        send_item(CMD_FEED, 8'hFF, 8'h00);
        send_read(8'd0);                        // nothing accepted yet
        send_read(8'd199);
        send_frame(8'hFF, 8'd0, FLAW_NONE);     // empty payload, CRC on header only
        send_frame(8'h5A, 8'd201, FLAW_LONG_LEN);
        send_frame(8'h33, 8'd0, FLAW_CRC);
        send_frame(8'h00, 8'd1, FLAW_NONE);
        send_read(8'd0);
        send_read(8'd1);                        // past the accepted length
    endtask

    task automatic test_max_length();
        gaps_on      = 1'b0;
        ready_stalls = 1'b1;
        read_mix     = 0;
        send_frame(8'hC3, 8'(MAX_LEN), FLAW_NONE);
        for (int i = 0; i < 10; i++)
            send_read(8'($urandom_range(MAX_LEN - 8, MAX_LEN - 1)));
        read_mix = 3;                           // reads interleaved with a new frame
        send_frame(8'h3C, 8'(MAX_LEN), FLAW_NONE);
        read_mix = 0;
        send_read(8'(MAX_LEN - 1));
        send_read(8'd128);
    endtask

    task automatic test_backpressure();
        gaps_on      = 1'b0;
        ready_stalls = 1'b0;
        hold_requests++;
        for (int i = 0; i < 80; i++)
        begin
            if (i % 8 == 0)
                send_frame(8'($urandom), 8'($urandom_range(0, 3)), FLAW_NONE);
            else
                send_read(pick_read_index());
        end
    endtask

    task automatic test_random_frames(input int item_target);
        int          r;
        frame_flaw_t flaw;
        logic [7:0]  plen;
        while (items_sent < item_target)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                gaps_on      = 1'($urandom_range(0, 1));
                ready_stalls = 1'($urandom_range(0, 1));
                read_mix     = $urandom_range(0, 30);
            end
            r = $urandom_range(0, 99);
            if (r < 80)
                plen = 8'($urandom_range(0, 8));
            else if (r < 95)
                plen = 8'($urandom_range(9, 40));
            else
                plen = 8'($urandom_range(41, MAX_LEN - 1));
            r = $urandom_range(0, 99);
            if (r < 75)
                flaw = FLAW_NONE;
            else if (r < 85)
                flaw = FLAW_CRC;
            else if (r < 92)
            begin
                flaw = FLAW_LONG_LEN;
                plen = 8'($urandom_range(MAX_LEN + 1, 255));
            end
            else
                flaw = FLAW_TRUNCATED;
            send_frame(8'($urandom), plen, flaw);
            if ($urandom_range(0, 3) == 0)
                send_noise($urandom_range(1, 2));
            if ($urandom_range(0, 2) == 0)
                send_read(pick_read_index());
        end
    endtask

    // Raw bytes, stray start bytes and cut-off headers
    task automatic test_noise();
        gaps_on      = 1'b1;
        ready_stalls = 1'b1;
        read_mix     = 10;
        for (int i = 0; i < 150; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                feed(SOP_BYTE);
            else
                feed(8'($urandom));
        end
    endtask

    initial
    begin
        int waited;
        for (int i = 0; i < MAX_LEN; i++)
            payload_mem[i] = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_max_length();
        test_backpressure();
        test_random_frames(1300);
        test_noise();
        in_valid <= 1'b0;

        waited = 0;
        while (pending_results.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (pending_results.size() > 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end

        $display("Sent %0d input transfers; checked %0d accepted packets and %0d payload reads.",
                 items_sent, packets_seen, reads_seen);
        if (errors == 0)
            $display("crc16_packet_deframer regression: pass");
        else
            $display("crc16_packet_deframer regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/crcpd_pkg.sv
hdl/crcpd_ram.sv
hdl/crcpd_rx.sv
hdl/crc16_packet_deframer.sv
dv/tb_top.sv
